>>> hdl/awg_pkg.sv
`default_nettype none

package awg_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int FULL_SCALE  = 4090;
    localparam int HALF_SCALE  = FULL_SCALE / 2;

    localparam int IDX_W    = 12;
    localparam int PERIOD_W = 13;
    localparam int PCT_W    = 7;
    localparam int LEVEL_W  = 12;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = 19;
    localparam int NUM_W    = 25;
    localparam int QUO_W    = 12;
    localparam int SINE_W   = 15;
    localparam int QTR_PTS  = 1025;
    localparam int QTR_AW   = 11;

    // latency from accept to result strobe
    localparam int LATENCY = 3 + QUO_W + 2;

    // floor(x / 100) as (x * RECIP_100) >> RECIP_SH for x below 2^19
    localparam logic [19:0] RECIP_100 = 20'd671089;
    localparam int          RECIP_SH  = 26;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PCT    = 2'd2;

    typedef enum logic [1:0] {
        MODE_DC   = 2'd0,
        MODE_SINE = 2'd1,
        MODE_TRI  = 2'd2,
        MODE_RECT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DIRECT = 2'd0,
        KIND_SINE   = 2'd1,
        KIND_RISE   = 2'd2,
        KIND_FALL   = 2'd3
    } t_kind;

    typedef struct packed {
        logic                oor;
        t_kind               kind;
        logic [LEVEL_W-1:0]  level;
    } t_tag;

    typedef logic [SINE_W-1:0] t_qsine [0:QTR_PTS-1];

    // quarter wave of round(32767 * sin(2 pi k / 4096)), k = 0 .. 1024
    function automatic t_qsine f_qsine();
        t_qsine tab;
        real    x;
        for (int k = 0; k < QTR_PTS; k++) begin
            x = 3.141592653589793 * real'(k) / 2048.0;
            tab[k] = SINE_W'($rtoi(32767.0 * $sin(x) + 0.5));
        end
        return tab;
    endfunction

    localparam t_qsine QSINE = f_qsine();

endpackage

`default_nettype wire

>>> hdl/awg_waveform_sample_top.sv
// waveform sample generator: dc, sine, triangle and rectangle levels
// command channel: start transfers sample_index when busy is low; busy stays
// low, so one index may be transferred in every clock cycle
// result channel: o_strobe marks one cycle holding o_dac_level and
// o_out_of_range; the receiver cannot stall, each result is taken as shown
// throughput one item per cycle; the pipeline holds these stages in order:
// three setup stages (percent products, divide by 100, numerator select),
// twelve stages of a pipelined restoring divider (one quotient bit each),
// one sine lookup stage and one output scaling stage
// configuration: write enable, register index (0 mode, 1 period, 2 percent)
// and data; writes take effect at once and belong to idle periods only
// reset (synchronous, active low) clears the pipeline valid bits and loads
// mode dc, period 4096 and percent 50
`default_nettype none

module awg_waveform_sample_top (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire  [awg_pkg::IDX_W-1:0]       i_sample_index,
    input  wire                             i_cfg_we,
    input  wire  [awg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [awg_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                            o_strobe,
    output logic [awg_pkg::LEVEL_W-1:0]     o_dac_level,
    output logic                            o_out_of_range
);

    localparam int QW = awg_pkg::QUO_W;
    localparam int NW = awg_pkg::NUM_W;
    localparam int PW = awg_pkg::PERIOD_W;
    localparam int LW = awg_pkg::LEVEL_W;
    localparam int IW = awg_pkg::IDX_W;

    localparam logic [LW-1:0] FS = LW'(awg_pkg::FULL_SCALE);

    // configuration registers
    logic [1:0]                 r_mode;
    logic [PW-1:0]              r_period;
    logic [awg_pkg::PCT_W-1:0]  r_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= awg_pkg::MODE_DC;
            r_period <= PW'(awg_pkg::MAX_SAMPLES);
            r_pct    <= 7'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                awg_pkg::CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                awg_pkg::CFG_PERIOD: r_period <= i_cfg_data;
                awg_pkg::CFG_PCT:    r_pct    <= i_cfg_data[awg_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: saturate, range check, percent products
    logic                       n_acc;
    logic [PW-1:0]              n_nsat;
    logic [awg_pkg::PCT_W-1:0]  n_psat;

    assign n_acc  = start && !busy;
    assign n_nsat = (r_period > PW'(awg_pkg::MAX_SAMPLES)) ? PW'(awg_pkg::MAX_SAMPLES)
                                                           : r_period;
    assign n_psat = (r_pct > 7'd100) ? 7'd100 : r_pct;

    logic                          r1_vld;
    logic [IW-1:0]                 r1_idx;
    logic [1:0]                    r1_mode;
    logic [PW-1:0]                 r1_n;
    logic                          r1_oor;
    logic [awg_pkg::PROD_W-1:0]    r1_pb;
    logic [awg_pkg::PROD_W-1:0]    r1_pd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= n_acc;
        end
        r1_idx  <= i_sample_index;
        r1_mode <= r_mode;
        r1_n    <= n_nsat;
        r1_oor  <= {1'b0, i_sample_index} >= n_nsat;
        r1_pb   <= awg_pkg::PROD_W'(n_nsat) * awg_pkg::PROD_W'(n_psat);
        r1_pd   <= awg_pkg::PROD_W'(FS) * awg_pkg::PROD_W'(n_psat);
    end

    // stage 2: divide both products by 100
    logic [awg_pkg::PROD_W+19:0] n_qb;
    logic [awg_pkg::PROD_W+19:0] n_qd;

    assign n_qb = r1_pb * awg_pkg::RECIP_100;
    assign n_qd = r1_pd * awg_pkg::RECIP_100;

    logic            r2_vld;
    logic [IW-1:0]   r2_idx;
    logic [1:0]      r2_mode;
    logic [PW-1:0]   r2_n;
    logic            r2_oor;
    logic [PW-1:0]   r2_b;
    logic [LW-1:0]   r2_dc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_idx  <= r1_idx;
        r2_mode <= r1_mode;
        r2_n    <= r1_n;
        r2_oor  <= r1_oor;
        r2_b    <= n_qb[awg_pkg::RECIP_SH +: PW];
        r2_dc   <= n_qd[awg_pkg::RECIP_SH +: LW];
    end

    // stage 3: pick dividend and divisor
    typedef awg_pkg::t_tag t_tag_local;

    logic            n_up;
    logic [PW-1:0]   n_span;
    logic [IW-1:0]   n_mop;
    logic [23:0]     n_mprod;
    t_tag_local      n_tag;
    logic [NW-1:0]   n_num;
    logic [PW-1:0]   n_div;

    assign n_up    = {1'b0, r2_idx} <= r2_b;
    assign n_span  = r2_n - r2_b;
    assign n_mop   = n_up ? r2_idx : IW'({1'b0, r2_idx} - r2_b);
    assign n_mprod = 24'(n_mop) * 24'(FS);

    always_comb begin
        n_tag.oor   = r2_oor;
        n_tag.kind  = awg_pkg::KIND_DIRECT;
        n_tag.level = '0;
        n_num       = NW'(n_mprod);
        n_div       = r2_b;
        case (awg_pkg::t_mode'(r2_mode))
            awg_pkg::MODE_DC: begin
                n_tag.level = r2_dc;
            end
            awg_pkg::MODE_SINE: begin
                n_tag.kind = awg_pkg::KIND_SINE;
                n_num      = NW'({r2_idx, 12'b0});
                n_div      = r2_n;
            end
            awg_pkg::MODE_TRI: begin
                if (n_up && r2_b == '0) begin
                    n_tag.level = FS;
                end else if (n_up) begin
                    n_tag.kind = awg_pkg::KIND_RISE;
                end else begin
                    n_tag.kind = awg_pkg::KIND_FALL;
                    n_num      = NW'(n_mprod) + NW'(n_span) - NW'(1);
                    n_div      = n_span;
                end
            end
            awg_pkg::MODE_RECT: begin
                n_tag.level = n_up ? FS : '0;
            end
            default: ;
        endcase
    end

    // pipelined restoring divider, one quotient bit per stage
    logic            r_dv  [0:QW];
    t_tag_local      r_dt  [0:QW];
    logic [NW-1:0]   r_rem [0:QW];
    logic [PW-1:0]   r_dd  [0:QW];
    logic [QW-1:0]   r_q   [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r2_vld;
        end
        r_dt[0]  <= n_tag;
        r_rem[0] <= n_num;
        r_dd[0]  <= n_div;
        r_q[0]   <= '0;
    end

    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int BIT = QW - 1 - s;
        logic [NW-1:0] n_sh;
        logic          n_ge;

        assign n_sh = NW'(r_dd[s]) << BIT;
        assign n_ge = r_rem[s] >= n_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s+1] <= 1'b0;
            end else begin
                r_dv[s+1] <= r_dv[s];
            end
            r_dt[s+1]  <= r_dt[s];
            r_dd[s+1]  <= r_dd[s];
            r_rem[s+1] <= n_ge ? r_rem[s] - n_sh : r_rem[s];
            r_q[s+1]   <= r_q[s] | (QW'(n_ge) << BIT);
        end
    end

    // stage d: finish triangle levels, sine table lookup
    logic [QW-1:0]                 n_q;
    logic [awg_pkg::QTR_AW-1:0]    n_addr;
    logic [LW-1:0]                 n_lvl;

    assign n_q    = r_q[QW];
    assign n_addr = n_q[10] ? awg_pkg::QTR_AW'(11'd1024 - {1'b0, n_q[9:0]})
                            : {1'b0, n_q[9:0]};

    always_comb begin
        case (r_dt[QW].kind)
            awg_pkg::KIND_RISE: n_lvl = n_q;
            awg_pkg::KIND_FALL: n_lvl = (n_q >= FS) ? '0 : FS - n_q;
            default:            n_lvl = r_dt[QW].level;
        endcase
    end

    logic                          rd_vld;
    logic                          rd_oor;
    logic                          rd_sine;
    logic                          rd_neg;
    logic [awg_pkg::SINE_W-1:0]    rd_sv;
    logic [LW-1:0]                 rd_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_vld <= 1'b0;
        end else begin
            rd_vld <= r_dv[QW];
        end
        rd_oor  <= r_dt[QW].oor;
        rd_sine <= r_dt[QW].kind == awg_pkg::KIND_SINE;
        rd_neg  <= n_q[11];
        rd_sv   <= awg_pkg::QSINE[n_addr];
        rd_lvl  <= n_lvl;
    end

    // stage e: scale sine to the dac range, output register
    logic [15:0] n_u;
    logic [27:0] n_sp;

    assign n_u  = rd_neg ? 16'd32768 - {1'b0, rd_sv} : 16'd32768 + {1'b0, rd_sv};
    assign n_sp = 28'(n_u) * 28'(awg_pkg::HALF_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= rd_vld;
        end
        o_out_of_range <= rd_oor;
        if (rd_oor) begin
            o_dac_level <= '0;
        end else if (rd_sine) begin
            o_dac_level <= n_sp[15 +: LW];
        end else begin
            o_dac_level <= rd_lvl;
        end
    end

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_out_of_range |-> o_dac_level == '0)
        else $error("out of range result with nonzero level");

    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_dac_level <= FS)
        else $error("level above full scale");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##(awg_pkg::LATENCY) o_strobe)
        else $error("result strobe missing after transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dv[0] |-> ##(QW + 2) !o_strobe)
        else $error("result strobe without an item in the divider");

endmodule

`default_nettype wire
